FILE: rtl/core/idld_pkg.sv
`timescale 1ns / 1ps
package idld_pkg;

  localparam int SLOT_COUNT    = 64;
  localparam int PAYLOAD_BYTES = 8;
  localparam int SLOT_W        = 7;
  localparam int ADDR_W        = 6;
  localparam int PAY_W         = 64;
  localparam int CMD_W         = 3;
  localparam int STS_W         = 2;
  localparam int BC_W          = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_HEAD_ADD = 3'd0,
    CMD_TAIL_ADD = 3'd1,
    CMD_HEAD_RM  = 3'd2,
    CMD_TAIL_RM  = 3'd3,
    CMD_IDX_RM   = 3'd4,
    CMD_READ     = 3'd5,
    CMD_CLEAR    = 3'd6,
    CMD_NOP      = 3'd7
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_NOT_IN = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY    = 2'd0,
    REG_ENTRY_BYTES = 2'd1
  } cfg_reg_t;

  // strobes from controller to datapath
  typedef struct packed {
    logic load;
    logic dec;
    logic search;
    logic add_a;
    logic add_b;
    logic rm_wr;
    logic rd_fin;
    logic done;
  } ctl_t;

  // decode flags from datapath to controller
  typedef struct packed {
    logic is_add;
    logic is_rm;
    logic is_read;
    logic add_full;
    logic rm_fail;
    logic free_hit;
  } sts_t;

  function automatic logic [PAY_W-1:0] byte_mask(input logic [BC_W-1:0] n);
    logic [PAY_W-1:0] m;
    m = '0;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      if (BC_W'(i) < n) m[8*i +: 8] = 8'hff;
    end
    return m;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] t;
    t = s - SLOT_W'(1);
    return t[ADDR_W-1:0];
  endfunction

endpackage

FILE: rtl/core/idld_ctrl.sv
`timescale 1ns / 1ps
module idld_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  idld_pkg::sts_t sts,
  output idld_pkg::ctl_t ctl
);
  import idld_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_DECODE = 8'b00000010,
    S_SEARCH = 8'b00000100,
    S_ADD_A  = 8'b00001000,
    S_ADD_B  = 8'b00010000,
    S_RM_WR  = 8'b00100000,
    S_RD_FIN = 8'b01000000,
    S_DONE   = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        ctl.dec = 1'b1;
        if (sts.is_add) state_nxt = sts.add_full ? S_DONE : S_SEARCH;
        else if (sts.is_rm) state_nxt = sts.rm_fail ? S_DONE : S_RM_WR;
        else if (sts.is_read) state_nxt = S_RD_FIN;
        else state_nxt = S_DONE;
      end
      S_SEARCH: begin
        ctl.search = 1'b1;
        if (sts.free_hit) state_nxt = S_ADD_A;
      end
      S_ADD_A: begin
        ctl.add_a = 1'b1;
        state_nxt = S_ADD_B;
      end
      S_ADD_B: begin
        ctl.add_b = 1'b1;
        state_nxt = S_DONE;
      end
      S_RM_WR: begin
        ctl.rm_wr = 1'b1;
        state_nxt = S_DONE;
      end
      S_RD_FIN: begin
        ctl.rd_fin = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ctl.done  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.done) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/core/idld_datapath.sv
`timescale 1ns / 1ps
module idld_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  idld_pkg::ctl_t                    ctl,
  output idld_pkg::sts_t                    sts,
  input  logic                              cfg_we,
  input  logic [idld_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [idld_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [idld_pkg::CMD_W-1:0]        in_command,
  input  logic [idld_pkg::SLOT_W-1:0]       in_slot_index,
  input  logic [idld_pkg::PAY_W-1:0]        in_payload_in,
  input  logic [idld_pkg::BC_W-1:0]         in_byte_count,
  output logic [idld_pkg::STS_W-1:0]        out_status,
  output logic [idld_pkg::SLOT_W-1:0]       out_slot_out,
  output logic [idld_pkg::PAY_W-1:0]        out_payload_out,
  output logic [idld_pkg::SLOT_W-1:0]       out_occupancy
);
  import idld_pkg::*;

  logic [SLOT_W-1:0] cap_r;
  logic [BC_W-1:0]   eb_r;

  cmd_t              cmd_r;
  logic [SLOT_W-1:0] idx_r;
  logic [PAY_W-1:0]  pin_r;
  logic [PAY_W-1:0]  mask_r;

  logic [SLOT_W-1:0] head_r, tail_r, ptr_r, count_r, scan_r, slot_r;
  logic [SLOT_COUNT-1:0] valid_r, written_r;
  logic              rd_ok_r;
  status_t           res_status_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic [PAY_W-1:0]  res_pay_r;

  logic [SLOT_W-1:0] fwd_mem [SLOT_COUNT];
  logic [SLOT_W-1:0] bwd_mem [SLOT_COUNT];
  logic [PAY_W-1:0]  pay_mem [SLOT_COUNT];
  logic [SLOT_W-1:0] fwd_q, bwd_q;
  logic [PAY_W-1:0]  pay_q;
  logic              pay_wq;

  logic [SLOT_W-1:0] cap_eff, sel_s, scan_nxt, start_p;
  logic [BC_W-1:0]   eb_sat, bc_sat, n_copy;
  logic              sel_in_range, sel_valid, scan_free;
  status_t           rm_status;
  logic [PAY_W-1:0]  old_pay, merged;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              fwd_we, bwd_we, pay_we;
  logic [ADDR_W-1:0] fwd_wa, bwd_wa, pay_wa;
  logic [SLOT_W-1:0] fwd_wd, bwd_wd;

  assign cap_eff = (cap_r > SLOT_W'(SLOT_COUNT)) ? SLOT_W'(SLOT_COUNT) : cap_r;
  assign eb_sat  = (eb_r > BC_W'(PAYLOAD_BYTES)) ? BC_W'(PAYLOAD_BYTES) : eb_r;
  assign bc_sat  = (in_byte_count > BC_W'(PAYLOAD_BYTES)) ? BC_W'(PAYLOAD_BYTES)
                                                         : in_byte_count;
  assign n_copy  = (bc_sat < eb_sat) ? bc_sat : eb_sat;

  always_comb begin
    case (cmd_r)
      CMD_HEAD_RM: sel_s = head_r;
      CMD_TAIL_RM: sel_s = tail_r;
      default:     sel_s = idx_r;
    endcase
  end

  assign sel_in_range = (sel_s != '0) && (sel_s <= SLOT_W'(SLOT_COUNT));
  assign sel_valid    = sel_in_range && valid_r[slot_addr(sel_s)];

  always_comb begin
    if (count_r == '0) rm_status = ST_EMPTY;
    else if (cmd_r == CMD_IDX_RM && (sel_s > cap_eff || !sel_valid)) rm_status = ST_NOT_IN;
    else if (!sel_valid) rm_status = ST_EMPTY;
    else rm_status = ST_OK;
  end

  assign start_p   = (ptr_r == '0 || ptr_r > cap_eff) ? SLOT_W'(1) : ptr_r;
  assign scan_nxt  = (scan_r >= cap_eff) ? SLOT_W'(1) : scan_r + SLOT_W'(1);
  assign scan_free = !valid_r[slot_addr(scan_r)];

  assign sts.is_add   = (cmd_r == CMD_HEAD_ADD) || (cmd_r == CMD_TAIL_ADD);
  assign sts.is_rm    = (cmd_r == CMD_HEAD_RM) || (cmd_r == CMD_TAIL_RM) ||
                        (cmd_r == CMD_IDX_RM);
  assign sts.is_read  = (cmd_r == CMD_READ);
  assign sts.add_full = (count_r >= cap_eff);
  assign sts.rm_fail  = (rm_status != ST_OK);
  assign sts.free_hit = scan_free;

  assign old_pay = pay_wq ? pay_q : '0;
  assign merged  = (old_pay & ~mask_r) | (pin_r & mask_r);

  // read port address
  assign rd_en   = ctl.dec || ctl.search;
  assign rd_addr = ctl.search ? slot_addr(scan_r)
                 : (cmd_r == CMD_READ) ? slot_addr(idx_r) : slot_addr(sel_s);

  // link write ports
  always_comb begin
    fwd_we = 1'b0; fwd_wa = slot_addr(slot_r); fwd_wd = '0;
    bwd_we = 1'b0; bwd_wa = slot_addr(slot_r); bwd_wd = '0;
    if (ctl.add_a) begin
      fwd_we = 1'b1;
      bwd_we = 1'b1;
      if (cmd_r == CMD_HEAD_ADD) fwd_wd = head_r;
      else bwd_wd = tail_r;
    end else if (ctl.add_b) begin
      if (cmd_r == CMD_HEAD_ADD) begin
        bwd_we = (head_r != '0);
        bwd_wa = slot_addr(head_r);
        bwd_wd = slot_r;
      end else begin
        fwd_we = (tail_r != '0);
        fwd_wa = slot_addr(tail_r);
        fwd_wd = slot_r;
      end
    end else if (ctl.rm_wr) begin
      fwd_we = (bwd_q != '0);
      fwd_wa = slot_addr(bwd_q);
      fwd_wd = fwd_q;
      bwd_we = (fwd_q != '0);
      bwd_wa = slot_addr(fwd_q);
      bwd_wd = bwd_q;
    end
  end

  assign pay_we = ctl.add_a;
  assign pay_wa = slot_addr(slot_r);

  always_ff @(posedge clk) begin
    if (fwd_we) fwd_mem[fwd_wa] <= fwd_wd;
  end

  always_ff @(posedge clk) begin
    if (bwd_we) bwd_mem[bwd_wa] <= bwd_wd;
  end

  always_ff @(posedge clk) begin
    if (pay_we) pay_mem[pay_wa] <= merged;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_q  <= fwd_mem[rd_addr];
      bwd_q  <= bwd_mem[rd_addr];
      pay_q  <= pay_mem[rd_addr];
      pay_wq <= written_r[rd_addr];
    end
  end

  // command, scan and result registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= cmd_t'(in_command);
      idx_r  <= in_slot_index;
      pin_r  <= in_payload_in;
      mask_r <= byte_mask(n_copy);
    end
    if (ctl.dec) begin
      res_status_r <= (sts.is_add && sts.add_full) ? ST_FULL :
                      sts.is_rm ? rm_status : ST_OK;
      res_slot_r   <= '0;
      res_pay_r    <= '0;
      rd_ok_r      <= (idx_r != '0) && (idx_r <= SLOT_W'(SLOT_COUNT));
      scan_r       <= start_p;
      slot_r       <= sel_s;
    end
    if (ctl.search) begin
      scan_r <= scan_nxt;
      if (scan_free) slot_r <= scan_r;
    end
    if (ctl.add_b) res_slot_r <= slot_r;
    if (ctl.rm_wr) res_pay_r <= old_pay & mask_r;
    if (ctl.rd_fin) res_pay_r <= rd_ok_r ? (old_pay & mask_r) : '0;
    if (ctl.done) begin
      out_status      <= res_status_r;
      out_slot_out    <= res_slot_r;
      out_payload_out <= res_pay_r;
      out_occupancy   <= count_r;
    end
  end

  // configuration and list control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= SLOT_W'(64);
      eb_r      <= BC_W'(8);
      head_r    <= '0;
      tail_r    <= '0;
      ptr_r     <= SLOT_W'(1);
      count_r   <= '0;
      valid_r   <= '0;
      written_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CAPACITY:    cap_r <= cfg_data;
          REG_ENTRY_BYTES: eb_r  <= cfg_data[BC_W-1:0];
          default:         ;
        endcase
      end
      if (ctl.dec && cmd_r == CMD_CLEAR) begin
        head_r  <= '0;
        tail_r  <= '0;
        ptr_r   <= SLOT_W'(1);
        count_r <= '0;
        valid_r <= '0;
      end
      if (ctl.search && scan_free) ptr_r <= scan_nxt;
      if (ctl.add_a) written_r[slot_addr(slot_r)] <= 1'b1;
      if (ctl.add_b) begin
        valid_r[slot_addr(slot_r)] <= 1'b1;
        count_r <= count_r + SLOT_W'(1);
        if (cmd_r == CMD_HEAD_ADD) begin
          head_r <= slot_r;
          if (head_r == '0) tail_r <= slot_r;
        end else begin
          tail_r <= slot_r;
          if (tail_r == '0) head_r <= slot_r;
        end
      end
      if (ctl.rm_wr) begin
        valid_r[slot_addr(slot_r)] <= 1'b0;
        count_r <= count_r - SLOT_W'(1);
        if (bwd_q == '0) head_r <= fwd_q;
        if (fwd_q == '0) tail_r <= bwd_q;
      end
    end
  end

endmodule

FILE: rtl/core/indexed_doubly_linked_deque_unit.sv
`timescale 1ns / 1ps
// each accepted word is decoded; then removes write the links, reads finish,
// and an add scans 1 to capacity slots one per cycle for a free one and then
// writes the payload and links; clear, a refused add or an unused command go
// straight to the result; the next word is taken the cycle after it registers
// synchronous active-low reset: empty list, search pointer 1, capacity 64,
// entry_bytes 8; payload reads of never-written slots return zero
module indexed_doubly_linked_deque_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [idld_pkg::CMD_W-1:0]        in_command,
  input  logic [idld_pkg::SLOT_W-1:0]       in_slot_index,
  input  logic [idld_pkg::PAY_W-1:0]        in_payload_in,
  input  logic [idld_pkg::BC_W-1:0]         in_byte_count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [idld_pkg::STS_W-1:0]        out_status,
  output logic [idld_pkg::SLOT_W-1:0]       out_slot_out,
  output logic [idld_pkg::PAY_W-1:0]        out_payload_out,
  output logic [idld_pkg::SLOT_W-1:0]       out_occupancy,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [idld_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [idld_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import idld_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // the user must write registers only while idle; the block itself does not enforce it, so the port is always open
  assign cfg_ready = 1'b1;

  // sequencer: decode, free-slot scan, two-step link update for adds, remove link write, read finish, result hand-off
  idld_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  // slot store: link and payload memories, valid bits, head/tail pointers
  idld_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .sts             (sts),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_command      (in_command),
    .in_slot_index   (in_slot_index),
    .in_payload_in   (in_payload_in),
    .in_byte_count   (in_byte_count),
    .out_status      (out_status),
    .out_slot_out    (out_slot_out),
    .out_payload_out (out_payload_out),
    .out_occupancy   (out_occupancy)
  );

  // an accepted word blocks the input until its result is registered
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  // occupancy stays within the slot store
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_occupancy <= SLOT_W'(SLOT_COUNT))
    else $error("occupancy beyond slot count");

  // a successful add leaves at least one element and names a real slot
  a_add_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_slot_out != '0 |->
      out_occupancy != '0 && out_status == ST_OK &&
      out_slot_out <= SLOT_W'(SLOT_COUNT))
    else $error("add result inconsistent");

endmodule
